// ===== rtl/framed_channel_packet_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the framed channel packet parser
// Shared concurrent assertion forms, clocked on aclk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef FRAMED_CHANNEL_PACKET_PARSER_ASSERT_SVH
`define FRAMED_CHANNEL_PACKET_PARSER_ASSERT_SVH

// Same-cycle implication.
`define FCPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FCPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fcpp_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpp_pkg
// Constants and shared types of the framed channel packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fcpp_pkg;

    localparam logic [7:0] HDR_START = 8'h24;   // '$'
    localparam logic [7:0] HDR_ID    = 8'h50;   // 'P'

    localparam int NUM_SIGNALS  = 4;
    localparam int CHANNELS_DEF = 4;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int SIG_IDX_W = 2;
    localparam int CH_IDX_W  = 3;

    // Control handed to the word chain every cycle.
    typedef struct packed {
        logic                shift;
        logic [WORD_W-1:0]   word;
    } chain_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/fcpp_cell.sv =====
// ----------------------------------------------------------------------------
// fcpp_cell
// One 16-bit word cell of the payload chain.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpp_cell
    import fcpp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              shift,
    input  wire logic [WORD_W-1:0] din,
    output logic      [WORD_W-1:0] dout
);

    logic [WORD_W-1:0] word_reg;

    // Payload storage: no reset, every entry is written before it is read.
    always_ff @(posedge aclk) begin
        if (shift) begin
            word_reg <= din;
        end
    end

    assign dout = word_reg;

endmodule

`default_nettype wire

// ===== rtl/fcpp_chain.sv =====
// ----------------------------------------------------------------------------
// fcpp_chain
// Row of word cells; words enter at the tail and leave from the head.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpp_chain
    import fcpp_pkg::*;
#(
    parameter int NUM_WORDS = NUM_SIGNALS * CHANNELS_DEF
) (
    input  wire logic              aclk,
    input  wire chain_ctrl_t       ctrl,
    output logic      [WORD_W-1:0] head_word
);

    logic [WORD_W-1:0] cell_out [NUM_WORDS];

    for (genvar i = 0; i < NUM_WORDS; i++) begin : g_cell
        logic [WORD_W-1:0] cell_in;

        if (i == NUM_WORDS - 1) begin : g_tail
            assign cell_in = ctrl.word;
        end else begin : g_body
            assign cell_in = cell_out[i+1];
        end

        fcpp_cell u_cell (
            .aclk  (aclk),
            .shift (ctrl.shift),
            .din   (cell_in),
            .dout  (cell_out[i])
        );
    end

    assign head_word = cell_out[0];

endmodule

`default_nettype wire

// ===== rtl/framed_channel_packet_parser.sv =====
// Latency: the first channel value is offered in the cycle after the check byte is accepted.
// Throughput: one received byte per cycle while hunting for a header or taking payload.
// After a good frame, 4 x CHANNELS values leave the chain head at one per cycle while
// m_ready is high, and no byte is accepted until the last of them has been taken.
// Reset (aresetn low, synchronous) clears the parser state, checksum and counters; the chain
// contents are not reset.
// ----------------------------------------------------------------------------
// framed_channel_packet_parser
// Hunts for a '$' 'P' header, collects the payload words into a chain of cells
// while accumulating an XOR checksum, and on a matching check byte emits one
// item per channel value.
// ----------------------------------------------------------------------------
`default_nettype none

`include "framed_channel_packet_parser_assert.svh"

module framed_channel_packet_parser
    import fcpp_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [BYTE_W-1:0]    s_rx_byte,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [SIG_IDX_W-1:0] m_signal_index,
    output logic      [CH_IDX_W-1:0]  m_channel_index,
    output logic      [WORD_W-1:0]    m_channel_value,
    output logic                      m_last
);

    localparam int NUM_WORDS     = NUM_SIGNALS * CHANNELS;
    localparam int PAYLOAD_BYTES = 2 * NUM_WORDS;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES);

    localparam logic [CNT_W-1:0]     LAST_BYTE  = CNT_W'(PAYLOAD_BYTES - 1);
    localparam logic [CH_IDX_W-1:0]  LAST_CH    = CH_IDX_W'(CHANNELS - 1);
    localparam logic [SIG_IDX_W-1:0] LAST_SIG   = SIG_IDX_W'(NUM_SIGNALS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOLLAR,
        ST_PAYLOAD,
        ST_CHECK,
        ST_DRAIN
    } state_t;

    state_t                 state_reg;
    logic [BYTE_W-1:0]      xor_reg;
    logic [BYTE_W-1:0]      lo_byte_reg;
    logic [CNT_W-1:0]       byte_cnt_reg;
    logic [SIG_IDX_W-1:0]   sig_reg;
    logic [CH_IDX_W-1:0]    ch_reg;

    logic        in_fire;
    logic        out_fire;
    logic        out_last;
    chain_ctrl_t chain_ctrl;
    logic [WORD_W-1:0] head_word;

    // The parser takes no byte while a frame's values are being handed out.
    assign s_ready  = (state_reg != ST_DRAIN);
    assign m_valid  = (state_reg == ST_DRAIN);
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign out_last = (sig_reg == LAST_SIG) && (ch_reg == LAST_CH);

    // A word is pushed into the tail once its high byte arrives; while draining the same
    // shift moves the next word up to the head.
    assign chain_ctrl.shift = (in_fire && (state_reg == ST_PAYLOAD) && byte_cnt_reg[0])
                              || out_fire;
    assign chain_ctrl.word  = {s_rx_byte, lo_byte_reg};

    fcpp_chain #(
        .NUM_WORDS (NUM_WORDS)
    ) u_chain (
        .aclk      (aclk),
        .ctrl      (chain_ctrl),
        .head_word (head_word)
    );

    assign m_signal_index  = sig_reg;
    assign m_channel_index = ch_reg;
    assign m_channel_value = head_word;
    assign m_last          = out_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            xor_reg      <= '0;
            byte_cnt_reg <= '0;
            sig_reg      <= '0;
            ch_reg       <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire && (s_rx_byte == HDR_START)) begin
                        state_reg <= ST_DOLLAR;
                    end
                end
                ST_DOLLAR: begin
                    // Any byte other than 'P', a second '$' included, drops back to idle.
                    if (in_fire) begin
                        if (s_rx_byte == HDR_ID) begin
                            state_reg    <= ST_PAYLOAD;
                            xor_reg      <= '0;
                            byte_cnt_reg <= '0;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_PAYLOAD: begin
                    if (in_fire) begin
                        xor_reg <= xor_reg ^ s_rx_byte;
                        if (!byte_cnt_reg[0]) begin
                            lo_byte_reg <= s_rx_byte;
                        end
                        if (byte_cnt_reg == LAST_BYTE) begin
                            state_reg <= ST_CHECK;
                        end else begin
                            byte_cnt_reg <= byte_cnt_reg + 1'b1;
                        end
                    end
                end
                ST_CHECK: begin
                    if (in_fire) begin
                        sig_reg <= '0;
                        ch_reg  <= '0;
                        if (s_rx_byte == xor_reg) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (out_fire) begin
                        if (out_last) begin
                            state_reg <= ST_IDLE;
                        end else if (ch_reg == LAST_CH) begin
                            ch_reg  <= '0;
                            sig_reg <= sig_reg + 1'b1;
                        end else begin
                            ch_reg <= ch_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `FCPP_ASSERT_NOW(a_no_overlap, m_valid, !s_ready,
        "byte accepted while values are being emitted")
    `FCPP_ASSERT_NEXT(a_last_ends_frame, out_fire && m_last, !m_valid,
        "value emitted after the last one of a frame")
    `FCPP_ASSERT_NOW(a_drain_from_check, $rose(m_valid),
        $past(in_fire) && ($past(state_reg) == ST_CHECK),
        "emission started without an accepted check byte")
    `FCPP_ASSERT_NOW(a_channel_range, m_valid, ch_reg <= LAST_CH,
        "channel index beyond the configured channel count")

endmodule

`default_nettype wire

// ===== test/fcpp_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fcpp_tb_pkg
// Frame scoreboard for the packet parser: follows the header hunt, payload
// collection and XOR checksum, and queues the channel values owed.
// ----------------------------------------------------------------------------
package fcpp_tb_pkg;
    import fcpp_pkg::*;

    typedef enum logic [1:0] {
        HUNT_START,
        HUNT_ID,
        TAKE_PAYLOAD,
        TAKE_CHECK
    } parse_phase_t;

    typedef struct packed {
        logic [SIG_IDX_W-1:0] signal_index;
        logic [CH_IDX_W-1:0]  channel_index;
        logic [WORD_W-1:0]    channel_value;
        logic                 last;
    } channel_result_t;

    localparam int STORE_MASK  = 63;
    localparam int PRINT_LIMIT = 60;

    class frame_scoreboard;
        int unsigned       channels;
        int unsigned       payload_len;
        parse_phase_t      phase;
        logic [BYTE_W-1:0] checksum;
        logic [6:0]        bytes_left;
        logic [BYTE_W-1:0] frame_bytes [64];
        channel_result_t   owed [$];
        int unsigned       fail_count;

        function new(int unsigned n_channels);
            channels    = n_channels;
            payload_len = 2 * NUM_SIGNALS * n_channels;
            phase       = HUNT_START;
            checksum    = '0;
            bytes_left  = '0;
            fail_count  = 0;
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
        endfunction

        // Called for every received byte that the parser has accepted.
        function void note_byte(logic [BYTE_W-1:0] b);
            int unsigned     idx;
            int unsigned     w;
            channel_result_t r;
            case (phase)
                HUNT_START: begin
                    if (b == HDR_START) phase = HUNT_ID;
                end
                HUNT_ID: begin
                    if (b == HDR_ID) begin
                        phase      = TAKE_PAYLOAD;
                        checksum   = '0;
                        bytes_left = 7'(payload_len);
                    end else begin
                        phase = HUNT_START;
                    end
                end
                TAKE_PAYLOAD: begin
                    idx = (payload_len - bytes_left) & STORE_MASK;
                    frame_bytes[idx] = b;
                    checksum ^= b;
                    if (bytes_left != 0) bytes_left--;
                    if (bytes_left == 0) phase = TAKE_CHECK;
                end
                default: begin
                    phase = HUNT_START;
                    if (b == checksum) begin
                        for (int unsigned j = 0; j < NUM_SIGNALS; j++) begin
                            for (int unsigned k = 0; k < channels; k++) begin
                                w = j * channels + k;
                                r.signal_index  = SIG_IDX_W'(j);
                                r.channel_index = CH_IDX_W'(k);
                                r.channel_value = {frame_bytes[(2 * w + 1) & STORE_MASK],
                                                   frame_bytes[(2 * w) & STORE_MASK]};
                                r.last          = (w == NUM_SIGNALS * channels - 1);
                                owed.push_back(r);
                            end
                        end
                    end
                end
            endcase
        endfunction

        task report(string what);
            if (fail_count < PRINT_LIMIT) $display("MISMATCH: %s", what);
            fail_count++;
        endtask

        task check_result(channel_result_t got);
            channel_result_t want;
            if (owed.size() == 0) begin
                report($sformatf("unexpected value sig %0d ch %0d = %04h last %0b",
                                 got.signal_index, got.channel_index,
                                 got.channel_value, got.last));
                return;
            end
            want = owed.pop_front();
            if (got.signal_index !== want.signal_index)
                report($sformatf("signal_index %0d, wanted %0d",
                                 got.signal_index, want.signal_index));
            if (got.channel_index !== want.channel_index)
                report($sformatf("channel_index %0d, wanted %0d",
                                 got.channel_index, want.channel_index));
            if (got.channel_value !== want.channel_value)
                report($sformatf("channel_value %04h, wanted %04h (sig %0d ch %0d)",
                                 got.channel_value, want.channel_value,
                                 want.signal_index, want.channel_index));
            if (got.last !== want.last)
                report($sformatf("last %0b, wanted %0b (sig %0d ch %0d)",
                                 got.last, want.last,
                                 want.signal_index, want.channel_index));
        endtask
    endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives received bytes into the framed channel packet parser with random
// gaps and random back-pressure, predicts the channel values of every good
// frame and checks each value leaving the parser in order.
// ----------------------------------------------------------------------------
module tb_top;
    import fcpp_pkg::*;
    import fcpp_tb_pkg::*;

    localparam int CHANNELS_UT  = CHANNELS_DEF;
    localparam int PAYLOAD_LEN  = 2 * NUM_SIGNALS * CHANNELS_UT;
    localparam int ITEM_TARGET  = 370;
    localparam int HOLD_AT      = 20;    // values taken before the long hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 1500;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 40;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte       = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [SIG_IDX_W-1:0] m_signal_index;
    logic [CH_IDX_W-1:0]  m_channel_index;
    logic [WORD_W-1:0]    m_channel_value;
    logic                 m_last;

    frame_scoreboard      sb;
    logic [BYTE_W-1:0]    frame_body [PAYLOAD_LEN];
    int                   sent_items    = 0;
    int                   values_taken  = 0;
    int                   send_calm     = 0;
    int                   recv_calm     = 0;

    framed_channel_packet_parser #(
        .CHANNELS        (CHANNELS_UT)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_signal_index  (m_signal_index),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_last          (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Each side draws its wait before every item. Now and then a calm
    // stretch starts, during which that side never idles, so that runs of
    // back-to-back items are seen as well as scattered ones.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // Offers one byte and returns at the edge where it was accepted. Valid
    // is only lowered when a gap is wanted, so it is never dropped and
    // raised again within one time step.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b);
        sent_items++;
    endtask

    // Sends a whole frame built from frame_body. A spoilt frame carries a
    // check byte that differs from the XOR of its payload, so it must give
    // no values at all.
    task automatic send_frame(input bit spoil);
        logic [BYTE_W-1:0] xor_acc;
        logic [BYTE_W-1:0] check_byte;
        int                i;
        xor_acc = '0;
        send_byte(HDR_START);
        send_byte(HDR_ID);
        for (i = 0; i < PAYLOAD_LEN; i++) begin
            send_byte(frame_body[i]);
            xor_acc ^= frame_body[i];
        end
        check_byte = spoil ? xor_acc ^ BYTE_W'($urandom_range(1, 255)) : xor_acc;
        send_byte(check_byte);
    endtask

    // Random payload, leaning on the all-zero and all-one bytes now and then.
    function automatic void fill_random_body();
        int i;
        int pick;
        for (i = 0; i < PAYLOAD_LEN; i++) begin
            pick = $urandom_range(0, 7);
            if (pick == 0)
                frame_body[i] = '0;
            else if (pick == 1)
                frame_body[i] = '1;
            else
                frame_body[i] = BYTE_W'($urandom);
        end
    endfunction

    function automatic logic [BYTE_W-1:0] random_not_id();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom); while (b == HDR_ID);
        return b;
    endfunction

    // Stimulus: a directed opening, then random traffic until enough items
    // have been accepted, then a drain and the verdict.
    initial begin
        int i;
        int n;
        int r;
        sb = new(CHANNELS_UT);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // A second start byte is not the identifier, so the parser falls
        // back to hunting and the 'P' that follows is ignored.
        send_byte(HDR_START);
        send_byte(HDR_START);
        send_byte(HDR_ID);
        send_byte(8'h00);
        // Start byte followed by something other than the identifier.
        send_byte(HDR_START);
        send_byte(HDR_ID + 8'd1);
        send_byte(HDR_ID);

        // Good frame with extreme words and header bytes inside the payload,
        // which must be treated as data and folded into the checksum.
        for (i = 0; i < PAYLOAD_LEN / 2; i++) begin
            case (i % 4)
                0: {frame_body[2 * i + 1], frame_body[2 * i]} = 16'h0000;
                1: {frame_body[2 * i + 1], frame_body[2 * i]} = 16'hFFFF;
                2: {frame_body[2 * i + 1], frame_body[2 * i]} = {HDR_ID, HDR_START};
                default: {frame_body[2 * i + 1], frame_body[2 * i]} = 16'h8000 | 16'(i);
            endcase
        end
        send_frame(1'b0);

        // A frame with random payload and a wrong check byte.
        fill_random_body();
        send_frame(1'b1);

        // Good frame whose checksum is the start byte itself. Once used as
        // the check byte it must not open a new header, so the identifier
        // sent after it falls on an idle parser.
        foreach (frame_body[k]) frame_body[k] = '0;
        frame_body[0] = HDR_START;
        send_frame(1'b0);
        send_byte(HDR_ID);

        // Random part: mostly well-formed frames with random payload, with
        // spoilt checksums, line noise, broken headers and cut-short frames
        // mixed in. A cut-short frame is simply continued by whatever is
        // sent next.
        while (sent_items < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                fill_random_body();
                send_frame(1'b0);
            end else if (r < 72) begin
                fill_random_body();
                send_frame(1'b1);
            end else if (r < 84) begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0)
                        send_byte(HDR_START);
                    else
                        send_byte(BYTE_W'($urandom));
                end
            end else if (r < 92) begin
                send_byte(HDR_START);
                if ($urandom_range(0, 1) == 1)
                    send_byte(HDR_START);
                else
                    send_byte(random_not_id());
            end else begin
                n = $urandom_range(1, PAYLOAD_LEN - 1);
                send_byte(HDR_START);
                send_byte(HDR_ID);
                repeat (n) send_byte(BYTE_W'($urandom));
            end
        end
        s_valid <= 1'b0;

        // Wait for every owed value, then give the parser time to show any
        // stray value before the verdict.
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.fail_count == 0)
            $display("framed_channel_packet_parser verification clean");
        else
            $display("framed_channel_packet_parser verification failed");
        $finish;
    end

    // Receiver: random back-pressure per value. Once, part-way through a
    // burst, ready is held low for a long stretch while the sender keeps
    // offering bytes, so the parser has to stall its input.
    initial begin
        int              gap;
        bit              held_off;
        channel_result_t got;
        held_off = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!held_off && values_taken >= HOLD_AT) begin
                held_off = 1'b1;
                gap      = HOLD_CYCLES;
            end else begin
                gap = draw_wait(recv_calm);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.signal_index  = m_signal_index;
            got.channel_index = m_channel_index;
            got.channel_value = m_channel_value;
            got.last          = m_last;
            sb.check_result(got);
            values_taken++;
        end
    end

    // Watchdog: ends the run if no item moves on either side for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        wait (aresetn);
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("framed_channel_packet_parser verification failed");
        $finish;
    end

endmodule
